// ----- design/temperature_median_decimator_defines.svh -----
// Assertion macros for the median decimator.
`ifndef TEMPERATURE_MEDIAN_DECIMATOR_DEFINES_SVH
`define TEMPERATURE_MEDIAN_DECIMATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TMD_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tmd assertion failed");
`define TMD_ASSERT_NEXT(label, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("tmd assertion failed");
`else
`define TMD_ASSERT(label, expr)
`define TMD_ASSERT_NEXT(label, trig, expr)
`endif

`endif

// ----- design/tmd_pkg.sv -----
package tmd_pkg;

    localparam int SAMPLE_COUNT_DEF = 5;
    localparam int SAMPLE_W         = 12;
    localparam int RAW_W            = 16;
    localparam int OUT_W            = 12;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // broadcast to every cell of the sorting row
    typedef struct packed {
        logic    ins;
        sample_t smp;
    } tmd_ins_t;

endpackage

// ----- design/tmd_cell.sv -----
// One slot of the sorted row. On insert, a cell whose value is above the new
// sample (or that is empty) takes either the new sample or its left neighbor.
module tmd_cell (
    input  logic               clk,
    input  tmd_pkg::tmd_ins_t  ins,
    input  logic               occupied,
    input  logic               prev_gt,
    input  tmd_pkg::sample_t   prev_val,
    output logic               gt,
    output tmd_pkg::sample_t   val
);

    tmd_pkg::sample_t val_reg;
    tmd_pkg::sample_t val_next;

    assign gt  = !occupied || (ins.smp < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ins.ins && gt)
        begin
            if (prev_gt)
                val_next = prev_val;
            else
                val_next = ins.smp;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- design/temperature_median_decimator.sv -----
// Median decimator: one reading per transaction, one result per SAMPLE_COUNT readings.
// Throughput: readings one per cycle within a group while s_axis_tready is high; the cells
// sort them as they arrive. Input is held off while pend_reg is set after a last reading, and
// a last reading waits while a result is held. pend_reg loads the scaled median and tvalid.
// Reset (rst_n low, asynchronous) empties the group and drops any held result.
`include "temperature_median_decimator_defines.svh"

module temperature_median_decimator #(
    parameter int SAMPLE_COUNT = tmd_pkg::SAMPLE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] raw_reading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [11:0] median_tenths, [15:12] zero
);

    localparam int CW  = $clog2(SAMPLE_COUNT + 1);
    localparam int MID = SAMPLE_COUNT / 2;
    localparam logic [CW-1:0] LAST_IDX = CW'(SAMPLE_COUNT - 1);
    localparam logic [tmd_pkg::RAW_W-1:0] SIGN_LIMIT = 16'd2000;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              pend_reg;
    logic              out_valid_reg;
    logic signed [tmd_pkg::OUT_W-1:0] out_data_reg;
    logic signed [tmd_pkg::OUT_W-1:0] out_data_next;

    logic              accept;
    logic              last_item;
    tmd_pkg::tmd_ins_t ins;
    tmd_pkg::sample_t  cell_val [SAMPLE_COUNT];
    logic              cell_gt  [SAMPLE_COUNT];

    logic signed [15:0] med_ext;
    logic signed [15:0] prod;
    logic signed [15:0] prod_adj;

    assign last_item     = (cnt_reg == LAST_IDX);
    assign s_axis_tready = !pend_reg && !(last_item && out_valid_reg);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // readings above the limit get sample bit 11 (the sign bit) forced high
    assign ins.ins = accept;
    assign ins.smp = (s_axis_tdata > SIGN_LIMIT) ? {1'b1, s_axis_tdata[10:0]}
                                                 : s_axis_tdata[11:0];

    genvar gi;
    generate
        for (gi = 0; gi < SAMPLE_COUNT; gi++)
        begin : g_cell
            logic             p_gt;
            tmd_pkg::sample_t p_val;
            if (gi == 0)
            begin : g_first
                assign p_gt  = 1'b0;
                assign p_val = ins.smp;
            end
            else
            begin : g_rest
                assign p_gt  = cell_gt[gi-1];
                assign p_val = cell_val[gi-1];
            end
            tmd_cell u_cell (
                .clk      (clk),
                .ins      (ins),
                .occupied (cnt_reg > CW'(gi)),
                .prev_gt  (p_gt),
                .prev_val (p_val),
                .gt       (cell_gt[gi]),
                .val      (cell_val[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = last_item ? '0 : cnt_reg + CW'(1);
    end

    // x*10/16 truncated toward zero
    assign med_ext  = 16'(cell_val[MID]);
    assign prod     = (med_ext <<< 3) + (med_ext <<< 1);
    assign prod_adj = prod + (prod[15] ? 16'sd15 : 16'sd0);
    assign out_data_next = prod_adj[15:4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= accept && last_item;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg};

    `TMD_ASSERT(a_cnt_range, cnt_reg <= LAST_IDX)
    `TMD_ASSERT_NEXT(a_pend_to_out, pend_reg, out_valid_reg && !pend_reg)
    `TMD_ASSERT(a_pend_slot_free, !(pend_reg && out_valid_reg))

    generate
        for (gi = 1; gi < SAMPLE_COUNT; gi++)
        begin : g_chk
            `TMD_ASSERT(a_sorted, (cnt_reg > CW'(gi)) |-> (cell_val[gi-1] <= cell_val[gi]))
        end
    endgenerate

endmodule
